@@ rtl/core/ipv4_header_receive_check_macros.svh @@
// Assertion macros used by the checker file of the header receive check.
`ifndef IPV4_HEADER_RECEIVE_CHECK_MACROS_SVH
`define IPV4_HEADER_RECEIVE_CHECK_MACROS_SVH

// Same-cycle implication, sampled on clk, off while reset is held.
`define IPV4HC_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("ipv4hc assertion failed");

// Next-cycle implication, sampled on clk, off while reset is held.
`define IPV4HC_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("ipv4hc assertion failed");

`endif

@@ rtl/core/ipv4hc_pkg.sv @@
// Types and constants shared by the IPv4 header receive check.
package ipv4hc_pkg;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } in_item_t;

  typedef struct packed {
    logic        accepted;
    logic [2:0]  status;
    logic [15:0] packet_length;
  } out_item_t;

  // Verdict codes
  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_VERSION   = 3'd1;
  localparam logic [2:0] ST_HDR_LEN   = 3'd2;
  localparam logic [2:0] ST_TTL       = 3'd3;
  localparam logic [2:0] ST_DEST      = 3'd4;
  localparam logic [2:0] ST_CHECKSUM  = 3'd5;
  localparam logic [2:0] ST_TRUNCATED = 3'd6;

  localparam logic [3:0]  IP_VERSION     = 4'd4;
  localparam logic [3:0]  MIN_IHL        = 4'd5;
  localparam logic [15:0] BYTE_COUNT_MAX = 16'hffff;
  localparam logic [15:0] TTL_INDEX      = 16'd8;
  localparam logic [15:0] DST_FIRST      = 16'd16;
  localparam logic [15:0] DST_LAST       = 16'd19;
  localparam logic [31:0] BROADCAST_ADDR = 32'hffff_ffff;
  localparam logic [15:0] SUM_GOOD       = 16'hffff;

endpackage

@@ rtl/core/ipv4hc_in_stage.sv @@
// Input register stage: holds one byte request until the tracker takes it.
module ipv4hc_in_stage (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  ipv4hc_pkg::in_item_t in_data,
  input  logic                 take,
  output logic                 held_valid,
  output ipv4hc_pkg::in_item_t held_data
);

  logic                 valid_r, valid_nxt;
  ipv4hc_pkg::in_item_t data_r, data_nxt;

  assign in_ready = !valid_r || take;

  always_comb begin
    valid_nxt = valid_r;
    data_nxt  = data_r;
    if (in_valid && in_ready) begin
      valid_nxt = 1'b1;
      data_nxt  = in_data;
    end else if (take) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  assign held_valid = valid_r;
  assign held_data  = data_r;

endmodule

@@ rtl/core/ipv4hc_hdr_track.sv @@
// Header field capture, running checksum and end-of-packet verdict.
module ipv4hc_hdr_track (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  go,
  input  ipv4hc_pkg::in_item_t  item,
  input  logic [31:0]           local_addr,
  output ipv4hc_pkg::out_item_t verdict
);

  logic [15:0] cnt_r, cnt_nxt;
  logic [3:0]  ver_r, ver_nxt;
  logic [3:0]  ihl_r, ihl_nxt;
  logic [7:0]  ttl_r, ttl_nxt;
  logic [31:0] dst_r, dst_nxt;
  logic [7:0]  hold_r, hold_nxt;
  logic [15:0] sum_r, sum_nxt;

  logic [3:0]  ver_cap, ihl_cap;
  logic [7:0]  ttl_cap, hold_cap, b;
  logic [31:0] dst_cap;
  logic [15:0] sum_cap, cnt_inc, folded;
  logic [16:0] sum_wide;
  logic [5:0]  hdr_bytes;
  logic [2:0]  status;

  assign b         = item.data_byte;
  assign sum_wide  = {1'b0, sum_r} + {1'b0, hold_r, b};
  assign folded    = sum_wide[15:0] + {15'd0, sum_wide[16]};
  assign cnt_inc   = (cnt_r != ipv4hc_pkg::BYTE_COUNT_MAX) ? cnt_r + 16'd1 : cnt_r;
  assign hdr_bytes = {ihl_cap, 2'b00};

  always_comb begin
    ver_cap  = ver_r;
    ihl_cap  = ihl_r;
    ttl_cap  = ttl_r;
    dst_cap  = dst_r;
    if (cnt_r == 16'd0) begin
      ver_cap = b[7:4];
      ihl_cap = b[3:0];
    end else if (cnt_r == ipv4hc_pkg::TTL_INDEX) begin
      ttl_cap = b;
    end else if (cnt_r >= ipv4hc_pkg::DST_FIRST && cnt_r <= ipv4hc_pkg::DST_LAST) begin
      dst_cap = {dst_r[23:0], b};
    end
  end

  // Even header bytes wait as the high half; odd ones complete a word and fold in.
  always_comb begin
    hold_cap = hold_r;
    sum_cap  = sum_r;
    if (cnt_r < {10'd0, hdr_bytes}) begin
      if (!cnt_r[0]) begin
        hold_cap = b;
      end else begin
        sum_cap = folded;
      end
    end
  end

  always_comb begin
    if (ver_cap != ipv4hc_pkg::IP_VERSION) begin
      status = ipv4hc_pkg::ST_VERSION;
    end else if (ihl_cap < ipv4hc_pkg::MIN_IHL) begin
      status = ipv4hc_pkg::ST_HDR_LEN;
    end else if (cnt_inc < {10'd0, hdr_bytes}) begin
      status = ipv4hc_pkg::ST_TRUNCATED;
    end else if (ttl_cap == 8'd0) begin
      status = ipv4hc_pkg::ST_TTL;
    end else if (dst_cap != local_addr && dst_cap != ipv4hc_pkg::BROADCAST_ADDR) begin
      status = ipv4hc_pkg::ST_DEST;
    end else if (sum_cap != ipv4hc_pkg::SUM_GOOD) begin
      status = ipv4hc_pkg::ST_CHECKSUM;
    end else begin
      status = ipv4hc_pkg::ST_OK;
    end
  end

  assign verdict.accepted      = (status == ipv4hc_pkg::ST_OK);
  assign verdict.status        = status;
  assign verdict.packet_length = cnt_inc;

  // Advance on each byte; drop all packet state after the final one.
  always_comb begin
    cnt_nxt  = cnt_r;
    ver_nxt  = ver_r;
    ihl_nxt  = ihl_r;
    ttl_nxt  = ttl_r;
    dst_nxt  = dst_r;
    hold_nxt = hold_r;
    sum_nxt  = sum_r;
    if (go) begin
      if (item.last_byte) begin
        cnt_nxt  = '0;
        ver_nxt  = '0;
        ihl_nxt  = '0;
        ttl_nxt  = '0;
        dst_nxt  = '0;
        hold_nxt = '0;
        sum_nxt  = '0;
      end else begin
        cnt_nxt  = cnt_inc;
        ver_nxt  = ver_cap;
        ihl_nxt  = ihl_cap;
        ttl_nxt  = ttl_cap;
        dst_nxt  = dst_cap;
        hold_nxt = hold_cap;
        sum_nxt  = sum_cap;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      ver_r  <= '0;
      ihl_r  <= '0;
      ttl_r  <= '0;
      dst_r  <= '0;
      hold_r <= '0;
      sum_r  <= '0;
    end else begin
      cnt_r  <= cnt_nxt;
      ver_r  <= ver_nxt;
      ihl_r  <= ihl_nxt;
      ttl_r  <= ttl_nxt;
      dst_r  <= dst_nxt;
      hold_r <= hold_nxt;
      sum_r  <= sum_nxt;
    end
  end

endmodule

@@ rtl/core/ipv4hc_out_reg.sv @@
// Result register: holds one verdict request until the receiver takes it.
module ipv4hc_out_reg (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  load,
  input  ipv4hc_pkg::out_item_t load_data,
  output logic                  slot_free,
  output logic                  out_valid,
  input  logic                  out_ready,
  output ipv4hc_pkg::out_item_t out_data
);

  logic                  valid_r, valid_nxt;
  ipv4hc_pkg::out_item_t data_r, data_nxt;

  assign slot_free = !valid_r || out_ready;

  always_comb begin
    valid_nxt = valid_r;
    data_nxt  = data_r;
    if (load) begin
      valid_nxt = 1'b1;
      data_nxt  = load_data;
    end else if (out_ready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  assign out_valid = valid_r;
  assign out_data  = data_r;

endmodule

@@ rtl/core/ipv4_header_receive_check.sv @@
// Top level of the IPv4 header receive check.
//
// Bytes of an IPv4 packet enter on the in_ channel, one per request, in
// network order, with last_byte set on the final byte. One verdict per
// packet leaves on the out_ channel: accepted, a status code and the byte
// count of the packet (saturating at 65535). cfg_wr_en/cfg_wr_data load the
// local address that destinations are matched against; write it while idle.
// Throughput: one byte per cycle, unless a final byte waits for room in the
// result register. Field capture and the end-around checksum add are done
// combinationally from the input register; the verdict goes to the result register.
// Reset clears the local address, all packet state and the valid flags of both registers.
// While the receiver stalls, the verdict is held; header bytes keep flowing,
// and a following final byte waits in the input register, which then holds
// in_ready low until the verdict is taken.
module ipv4_header_receive_check (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  ipv4hc_pkg::in_item_t  in_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output ipv4hc_pkg::out_item_t out_data,
  input  logic                  cfg_wr_en,
  input  logic [31:0]           cfg_wr_data
);

  logic                  held_valid, take, slot_free;
  ipv4hc_pkg::in_item_t  held_data;
  ipv4hc_pkg::out_item_t verdict;
  logic [31:0]           local_addr_r, local_addr_nxt;

  assign local_addr_nxt = cfg_wr_en ? cfg_wr_data : local_addr_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      local_addr_r <= '0;
    end else begin
      local_addr_r <= local_addr_nxt;
    end
  end

  // A final byte needs room in the result register; others always proceed.
  assign take = held_valid && (!held_data.last_byte || slot_free);

  ipv4hc_in_stage u_in (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .take       (take),
    .held_valid (held_valid),
    .held_data  (held_data)
  );

  ipv4hc_hdr_track u_track (
    .clk        (clk),
    .rst_n      (rst_n),
    .go         (take),
    .item       (held_data),
    .local_addr (local_addr_r),
    .verdict    (verdict)
  );

  ipv4hc_out_reg u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (take && held_data.last_byte),
    .load_data (verdict),
    .slot_free (slot_free),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

@@ rtl/core/ipv4hc_checker.sv @@
// Port-level assertion checker for the IPv4 header receive check, with its bind.
`include "ipv4_header_receive_check_macros.svh"

module ipv4hc_checker (
  input logic                  clk,
  input logic                  rst_n,
  input logic                  out_valid,
  input logic                  out_ready,
  input ipv4hc_pkg::out_item_t out_data
);

  `IPV4HC_ASSERT_IMP(a_accept_matches_status, out_valid, out_data.accepted == (out_data.status == ipv4hc_pkg::ST_OK))
  `IPV4HC_ASSERT_IMP(a_status_defined, out_valid, out_data.status <= ipv4hc_pkg::ST_TRUNCATED)
  `IPV4HC_ASSERT_IMP(a_length_nonzero, out_valid, out_data.packet_length != 16'd0)
  `IPV4HC_ASSERT_NXT(a_stall_holds, out_valid && !out_ready, out_valid && $stable(out_data))

endmodule

bind ipv4_header_receive_check ipv4hc_checker u_ipv4hc_checker (.*);

@@ verif/tb_top.sv @@
// Self-checking testbench for the IPv4 header receive check, byte stream in, verdicts out.
`timescale 1ns / 100ps

module tb_top;

  localparam int CYCLE_LIMIT = 600000;
  localparam int LONG_HOLD   = 300;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  ipv4hc_pkg::in_item_t  in_data = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  ipv4hc_pkg::out_item_t out_data;
  logic                  cfg_wr_en = 1'b0;
  logic [31:0]           cfg_wr_data = '0;

  // Bytes waiting to be sent, verdicts waiting to arrive
  ipv4hc_pkg::in_item_t  bytes_to_send[$];
  ipv4hc_pkg::out_item_t verdicts_due[$];
  logic [7:0]            frame[$];
  int                    queued_items = 0;
  int                    mismatch_count = 0;
  int                    cycle_count = 0;

  // Sender and receiver pacing
  bit          tx_steady = 1'b0;
  bit          rx_steady = 1'b0;
  int          tx_gap = 0;
  int          rx_stall = 0;
  int          rx_hold_req = 0;
  int          rx_hold_done = 0;

  // Local copy of the header state
  logic [31:0] local_addr = '0;
  logic [15:0] rx_count = '0;
  logic [3:0]  cap_version = '0;
  logic [3:0]  cap_ihl = '0;
  logic [7:0]  cap_ttl = '0;
  logic [31:0] cap_dst = '0;
  logic [7:0]  held_high = '0;
  logic [15:0] hdr_sum = '0;

  ipv4_header_receive_check DUT (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_data     (in_data),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_data    (out_data),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  function automatic int pick_gap(input bit steady);
    int r;
    if (steady) return 0;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // Advance the header state by one byte; queue a verdict on the final byte
  function automatic void track_byte(input ipv4hc_pkg::in_item_t it);
    logic [15:0]           idx;
    logic [5:0]            hdr_len;
    logic [16:0]           s;
    logic [2:0]            st;
    ipv4hc_pkg::out_item_t v;
    idx = rx_count;
    if (idx == 16'd0) begin
      cap_version = it.data_byte[7:4];
      cap_ihl     = it.data_byte[3:0];
    end else if (idx == ipv4hc_pkg::TTL_INDEX) begin
      cap_ttl = it.data_byte;
    end else if (idx >= ipv4hc_pkg::DST_FIRST && idx <= ipv4hc_pkg::DST_LAST) begin
      cap_dst = {cap_dst[23:0], it.data_byte};
    end
    hdr_len = {cap_ihl, 2'b00};
    if (idx < 16'(hdr_len)) begin
      if (!idx[0]) begin
        held_high = it.data_byte;
      end else begin
        s = {1'b0, hdr_sum} + {1'b0, held_high, it.data_byte};
        hdr_sum = s[15:0] + 16'(s[16]);
      end
    end
    if (rx_count != ipv4hc_pkg::BYTE_COUNT_MAX) rx_count = rx_count + 16'd1;
    if (it.last_byte) begin
      if (cap_version != ipv4hc_pkg::IP_VERSION) st = ipv4hc_pkg::ST_VERSION;
      else if (cap_ihl < ipv4hc_pkg::MIN_IHL) st = ipv4hc_pkg::ST_HDR_LEN;
      else if (rx_count < 16'(hdr_len)) st = ipv4hc_pkg::ST_TRUNCATED;
      else if (cap_ttl == 8'd0) st = ipv4hc_pkg::ST_TTL;
      else if (cap_dst != local_addr && cap_dst != ipv4hc_pkg::BROADCAST_ADDR)
        st = ipv4hc_pkg::ST_DEST;
      else if (hdr_sum != ipv4hc_pkg::SUM_GOOD) st = ipv4hc_pkg::ST_CHECKSUM;
      else st = ipv4hc_pkg::ST_OK;
      v.accepted      = (st == ipv4hc_pkg::ST_OK);
      v.status        = st;
      v.packet_length = rx_count;
      verdicts_due.push_back(v);
      rx_count    = '0;
      cap_version = '0;
      cap_ihl     = '0;
      cap_ttl     = '0;
      cap_dst     = '0;
      held_high   = '0;
      hdr_sum     = '0;
    end
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    mismatch_count++;
    $display("%0t: mismatch on %s: got %0d, want %0d", $time, what, got, want);
  endtask

  task automatic check_verdict(input ipv4hc_pkg::out_item_t got);
    ipv4hc_pkg::out_item_t want;
    if (verdicts_due.size() == 0) begin
      report_mismatch("verdict with none due, status", int'(got.status), -1);
    end else begin
      want = verdicts_due.pop_front();
      if (got.accepted !== want.accepted)
        report_mismatch("accepted", int'(got.accepted), int'(want.accepted));
      if (got.status !== want.status)
        report_mismatch("status", int'(got.status), int'(want.status));
      if (got.packet_length !== want.packet_length)
        report_mismatch("packet_length", int'(got.packet_length), int'(want.packet_length));
    end
  endtask

  // Sender: hold the request until taken, then advance after an optional gap
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      in_data  <= '0;
      tx_gap   = 0;
    end else begin
      if (in_valid && in_ready) track_byte(in_data);
      if (!in_valid || in_ready) begin
        if (tx_gap > 0) begin
          tx_gap--;
          in_valid <= 1'b0;
        end else if (bytes_to_send.size() > 0) begin
          in_data  <= bytes_to_send.pop_front();
          in_valid <= 1'b1;
          tx_gap   = pick_gap(tx_steady);
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Receiver: check each verdict, stall now and then
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
      rx_stall  = 0;
    end else begin
      if (out_valid && out_ready) begin
        check_verdict(out_data);
        rx_stall = pick_gap(rx_steady);
      end
      if (rx_hold_done != rx_hold_req) begin
        rx_hold_done = rx_hold_req;
        rx_stall     = LONG_HOLD;
      end
      if (rx_stall > 0) begin
        rx_stall--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  task automatic queue_frame();
    ipv4hc_pkg::in_item_t it;
    int i;
    for (i = 0; i < frame.size(); i++) begin
      it.data_byte = frame[i];
      it.last_byte = (i == frame.size() - 1);
      bytes_to_send.push_back(it);
    end
    queued_items += frame.size();
  endtask

  task automatic queue_single(input logic [7:0] octet);
    frame = {};
    frame.push_back(octet);
    queue_frame();
  endtask

  // Header with random options and payload; checksum set correctly when ihl is at least MIN_IHL
  task automatic build_frame(input logic [3:0] ihl, input logic [7:0] ttl,
                             input logic [31:0] dst, input int payload);
    logic [16:0] s;
    logic [15:0] acc;
    int          hdr;
    int          i;
    hdr = int'(ihl) * 4;
    frame = {};
    frame.push_back({ipv4hc_pkg::IP_VERSION, ihl});
    for (i = 1; i < 20; i++) frame.push_back(8'($urandom));
    for (i = 20; i < hdr; i++) frame.push_back(8'($urandom));
    frame[8]  = ttl;
    frame[10] = 8'h00;
    frame[11] = 8'h00;
    frame[16] = dst[31:24];
    frame[17] = dst[23:16];
    frame[18] = dst[15:8];
    frame[19] = dst[7:0];
    if (ihl >= ipv4hc_pkg::MIN_IHL) begin
      acc = '0;
      for (i = 0; i < hdr; i += 2) begin
        s = {1'b0, acc} + {1'b0, frame[i], frame[i+1]};
        acc = s[15:0] + 16'(s[16]);
      end
      frame[10] = ~acc[15:8];
      frame[11] = ~acc[7:0];
    end
    for (i = 0; i < payload; i++) frame.push_back(8'($urandom));
  endtask

  // Mostly good packets, the rest broken in one way each or plain noise
  task automatic random_frame();
    int          kind;
    int          pay;
    int          pos;
    int          cut;
    int          ver;
    logic [3:0]  ihl;
    logic [7:0]  ttl;
    logic [31:0] dst;
    kind = $urandom_range(0, 99);
    ihl  = ($urandom_range(0, 99) < 60) ? ipv4hc_pkg::MIN_IHL : 4'($urandom_range(6, 15));
    pay  = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 48) : $urandom_range(0, 10);
    ttl  = 8'($urandom_range(1, 255));
    dst  = $urandom_range(0, 1) ? local_addr : ipv4hc_pkg::BROADCAST_ADDR;
    if (kind >= 95) begin
      frame = {};
      repeat ($urandom_range(1, 30)) frame.push_back(8'($urandom));
    end else begin
      if (kind >= 55 && kind < 62) ttl = 8'h00;
      if (kind >= 62 && kind < 70) dst = $urandom;
      if (kind >= 90) ihl = 4'($urandom_range(0, 4));
      build_frame(ihl, ttl, dst, pay);
      if (kind >= 70 && kind < 78) begin
        pos = $urandom_range(1, int'(ihl) * 4 - 1);
        frame[pos] = frame[pos] ^ (8'h01 << $urandom_range(0, 7));
      end
      if (kind >= 78 && kind < 85) begin
        cut = $urandom_range(1, int'(ihl) * 4 - 1);
        while (frame.size() > cut) void'(frame.pop_back());
      end
      if (kind >= 85 && kind < 90) begin
        ver = $urandom_range(0, 14);
        if (ver >= 4) ver++;
        frame[0] = {4'(ver), frame[0][3:0]};
      end
    end
    queue_frame();
  endtask

  task automatic run_random(input int count);
    int target;
    target = queued_items + count;
    while (queued_items < target) random_frame();
  endtask

  // Wait until every byte is taken and every verdict has come, then let the pipe settle
  task automatic wait_idle();
    do @(posedge clk);
    while (bytes_to_send.size() != 0 || in_valid || verdicts_due.size() != 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_local(input logic [31:0] addr);
    wait_idle();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= addr;
    local_addr  = addr;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: bad version, zero header length, header cut short, a good packet, bad version again
    queue_single(8'hff);
    queue_single(8'h40);
    queue_single(8'h45);
    build_frame(ipv4hc_pkg::MIN_IHL, 8'hff, ipv4hc_pkg::BROADCAST_ADDR, 0);
    queue_frame();
    queue_single(8'h00);

    write_local(32'hffff_ffff);
    run_random(350);

    // Long receiver hold while the sender keeps pushing short packets
    write_local($urandom);
    tx_steady = 1'b1;
    rx_hold_req++;
    repeat (10) queue_single(8'h45);
    run_random(450);
    wait_idle();
    tx_steady = 1'b0;

    write_local(32'h0000_0000);
    run_random(350);

    // Long packet sent without gaps
    write_local($urandom);
    tx_steady = 1'b1;
    rx_steady = 1'b1;
    build_frame(ipv4hc_pkg::MIN_IHL, 8'h40, local_addr, 200);
    queue_frame();
    wait_idle();
    tx_steady = 1'b0;
    rx_steady = 1'b0;

    write_local($urandom);
    run_random(350);

    wait_idle();
    repeat (8) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

@@ ipv4_header_receive_check.f @@
+incdir+rtl/core
rtl/core/ipv4hc_pkg.sv
rtl/core/ipv4hc_in_stage.sv
rtl/core/ipv4hc_hdr_track.sv
rtl/core/ipv4hc_out_reg.sv
rtl/core/ipv4_header_receive_check.sv
rtl/core/ipv4hc_checker.sv
verif/tb_top.sv
